// File: rtl/brb_pkg.sv
// Shared types, codes and constants for the circular byte FIFO.
package brb_pkg;

  localparam int DEPTH_DEFAULT     = 32;
  localparam int MAX_BURST_DEFAULT = 8;

  // The store is split into eight byte-wide banks, one per byte lane.
  localparam int LANE_W = 3;
  localparam int LANES  = 2 ** LANE_W;

  localparam int OP_W    = 2;
  localparam int COUNT_W = 4;
  localparam int DATA_W  = 64;
  localparam int CAP_W   = 6;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  data_in;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] got_count;
    logic [DATA_W-1:0]  data_out;
    logic [CAP_W-1:0]   fill_level;
  } rsp_t;

endpackage

// File: rtl/brb_bank.sv
// One byte-wide bank of the FIFO store: one write port, one registered read port.
module brb_bank #(
  parameter int ROW_W = 2
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ROW_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic [ROW_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [2**ROW_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/byte_ring_buffer_top.sv
// Circular byte FIFO top level: command register, pointer update, banked store, result.
// A command accepted at one edge has its result on the result ports from the next edge,
// strobed by done for one cycle.
// One command is taken in every cycle; busy never rises and the receiver cannot stall,
// so the rate is set by one row access per byte bank in each cycle.
// Reset clears the read pointer, the fill count and the pipeline valids and sets the
// capacity to DEPTH; store contents are not cleared.
module byte_ring_buffer_top #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEFAULT,
  parameter int MAX_BURST = brb_pkg::MAX_BURST_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  brb_pkg::cmd_t             cmd,
  output logic                      done,
  output brb_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [brb_pkg::CAP_W-1:0] cfg_data
);

  // Internal ring is a power of two of at least two rows of eight bytes. Bytes are
  // placed by their running position, so no capacity wrap is needed inside it:
  // the fill count never exceeds the capacity, which never exceeds the ring.
  localparam int PW_RAW = $clog2(DEPTH);
  localparam int PW     = (PW_RAW > brb_pkg::LANE_W + 1) ? PW_RAW : brb_pkg::LANE_W + 1;
  localparam int RW     = PW - brb_pkg::LANE_W;
  localparam int CW_RAW = $clog2(DEPTH + 1);
  localparam int CW     = (CW_RAW > brb_pkg::CAP_W) ? CW_RAW : brb_pkg::CAP_W;
  localparam int LW     = brb_pkg::LANE_W;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Command register.
  logic          cmd_valid;
  brb_pkg::cmd_t cmd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= cmd;
    end
  end

  // FIFO state.
  logic [CW-1:0] capacity;
  logic [CW-1:0] held;
  logic [PW-1:0] head;
  logic [CW-1:0] held_next;
  logic [PW-1:0] head_next;
  logic [CW-1:0] cap_next;

  logic [brb_pkg::COUNT_W-1:0] cnt;
  logic [brb_pkg::COUNT_W-1:0] got_n;
  logic [brb_pkg::COUNT_W-1:0] n;
  logic [CW-1:0]               free;
  logic                        reject;
  logic                        is_rd;
  logic                        do_write;
  logic [PW-1:0]               wpos;

  always_comb begin
    cnt = (cmd_r.count > brb_pkg::COUNT_W'(MAX_BURST)) ?
          brb_pkg::COUNT_W'(MAX_BURST) : cmd_r.count;
    free   = capacity - held;
    reject = (cmd_r.op == brb_pkg::OP_WRITE) && (free < CW'(cnt));
    is_rd  = (cmd_r.op == brb_pkg::OP_READ) || (cmd_r.op == brb_pkg::OP_PEEK);
    // When the fill count is not above the request it is at most eight, so it fits.
    got_n  = (CW'(cnt) < held) ? cnt : brb_pkg::COUNT_W'(held);
    n      = is_rd ? got_n : '0;
    do_write = cmd_valid && (cmd_r.op == brb_pkg::OP_WRITE) && !reject;
    wpos   = head + PW'(held);

    held_next = held;
    head_next = head;
    if (cmd_valid) begin
      case (cmd_r.op)
        brb_pkg::OP_WRITE: begin
          if (!reject) begin
            held_next = held + CW'(cnt);
          end
        end
        brb_pkg::OP_READ: begin
          held_next = held - CW'(n);
          head_next = head + PW'(n);
        end
        brb_pkg::OP_PEEK: begin
        end
        default: begin
          held_next = '0;
          head_next = '0;
        end
      endcase
    end

    // A capacity write is clamped into range and empties the buffer.
    if (cfg_data == '0) begin
      cap_next = CW'(1);
    end else if (32'(cfg_data) > DEPTH) begin
      cap_next = CW'(DEPTH);
    end else begin
      cap_next = CW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(DEPTH);
      held     <= '0;
      head     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cap_next;
      held     <= '0;
      head     <= '0;
    end else begin
      held <= held_next;
      head <= head_next;
    end
  end

  // Byte banks: lane b holds every byte whose ring position ends in b.
  logic [7:0] rdata [brb_pkg::LANES];

  for (genvar b = 0; b < brb_pkg::LANES; b++) begin : g_bank
    localparam logic [LW-1:0] BL = LW'(b);

    logic [LW-1:0] woff;
    logic          we;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;
    logic [RW-1:0] raddr;

    always_comb begin
      woff  = BL - wpos[LW-1:0];
      we    = do_write && (brb_pkg::COUNT_W'(woff) < cnt);
      waddr = wpos[PW-1:LW] + RW'(BL < wpos[LW-1:0]);
      wdata = cmd_r.data_in[8*woff +: 8];
      raddr = head[PW-1:LW] + RW'(BL < head[LW-1:0]);
    end

    brb_bank #(
      .ROW_W(RW)
    ) u_bank (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata[b])
    );
  end

  // Result register; read data arrives from the banks at the same edge.
  logic                        status_r;
  logic [brb_pkg::COUNT_W-1:0] got_r;
  logic [brb_pkg::CAP_W-1:0]   fill_r;
  logic [LW-1:0]               rot_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      status_r <= reject ? brb_pkg::STATUS_REJECT : brb_pkg::STATUS_DONE;
      got_r    <= n;
      fill_r   <= brb_pkg::CAP_W'(held_next);
      rot_r    <= head[LW-1:0];
    end
  end

  // Rotate the bank outputs so the oldest byte lands in lane zero.
  always_comb begin
    logic [LW-1:0] lane;
    lane = '0;
    rsp.status     = status_r;
    rsp.got_count  = got_r;
    rsp.fill_level = fill_r;
    rsp.data_out   = '0;
    for (int i = 0; i < brb_pkg::LANES; i++) begin
      lane = rot_r + LW'(i);
      if (brb_pkg::COUNT_W'(i) < got_r) begin
        rsp.data_out[8*i +: 8] = rdata[lane];
      end
    end
  end

endmodule
